>>> design/rv32_instruction_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// rv32 instruction decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RV32_INSTRUCTION_DECODER_TOP_MACROS_SVH
`define RV32_INSTRUCTION_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define RVID_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvid assertion failed");

// next-cycle implication
`define RVID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvid assertion failed");

`endif

>>> design/rvid_pkg.sv
// ----------------------------------------------------------------------------
// rvid_pkg
// Opcodes, operation numbers, format codes, control flags and the packed
// decode result shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package rvid_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    // major opcodes, bits 6:0
    localparam logic [6:0] OPC_R      = 7'b0110011;
    localparam logic [6:0] OPC_I      = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_FLOAD  = 7'b0000111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_FSTORE = 7'b0100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_FP     = 7'b1010011;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_MULD = 7'b0000001;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_FADD = 7'b0000000;
    localparam logic [6:0] F7_FSUB = 7'b0000100;

    // operation numbers
    localparam logic [5:0] OP_NONE   = 6'd0;
    localparam logic [5:0] OP_ADD    = 6'd1;
    localparam logic [5:0] OP_MUL    = 6'd2;
    localparam logic [5:0] OP_SUB    = 6'd3;
    localparam logic [5:0] OP_SLL    = 6'd4;
    localparam logic [5:0] OP_MULH   = 6'd5;
    localparam logic [5:0] OP_SLT    = 6'd6;
    localparam logic [5:0] OP_MULHSU = 6'd7;
    localparam logic [5:0] OP_SLTU   = 6'd8;
    localparam logic [5:0] OP_MULHU  = 6'd9;
    localparam logic [5:0] OP_XOR    = 6'd10;
    localparam logic [5:0] OP_DIV    = 6'd11;
    localparam logic [5:0] OP_SRL    = 6'd12;
    localparam logic [5:0] OP_DIVU   = 6'd13;
    localparam logic [5:0] OP_SRA    = 6'd14;
    localparam logic [5:0] OP_OR     = 6'd15;
    localparam logic [5:0] OP_REM    = 6'd16;
    localparam logic [5:0] OP_AND    = 6'd17;
    localparam logic [5:0] OP_REMU   = 6'd18;
    localparam logic [5:0] OP_ADDI   = 6'd19;
    localparam logic [5:0] OP_LB     = 6'd27;
    localparam logic [5:0] OP_LH     = 6'd28;
    localparam logic [5:0] OP_LW     = 6'd29;
    localparam logic [5:0] OP_LBU    = 6'd30;
    localparam logic [5:0] OP_LHU    = 6'd31;
    localparam logic [5:0] OP_LWU    = 6'd32;
    localparam logic [5:0] OP_FLW    = 6'd33;
    localparam logic [5:0] OP_SB     = 6'd34;
    localparam logic [5:0] OP_FSW    = 6'd37;
    localparam logic [5:0] OP_BEQ    = 6'd38;
    localparam logic [5:0] OP_BNE    = 6'd39;
    localparam logic [5:0] OP_BLT    = 6'd40;
    localparam logic [5:0] OP_BGE    = 6'd41;
    localparam logic [5:0] OP_BLTU   = 6'd42;
    localparam logic [5:0] OP_BGEU   = 6'd43;
    localparam logic [5:0] OP_JAL    = 6'd44;
    localparam logic [5:0] OP_JALR   = 6'd45;
    localparam logic [5:0] OP_LUI    = 6'd46;
    localparam logic [5:0] OP_AUIPC  = 6'd47;
    localparam logic [5:0] OP_FADD   = 6'd48;
    localparam logic [5:0] OP_FSUB   = 6'd49;

    // format codes
    localparam logic [3:0] FMT_UNKNOWN = 4'd0;
    localparam logic [3:0] FMT_R       = 4'd1;
    localparam logic [3:0] FMT_I       = 4'd2;
    localparam logic [3:0] FMT_LOAD    = 4'd3;
    localparam logic [3:0] FMT_FLOAD   = 4'd4;
    localparam logic [3:0] FMT_STORE   = 4'd5;
    localparam logic [3:0] FMT_FSTORE  = 4'd6;
    localparam logic [3:0] FMT_B       = 4'd7;
    localparam logic [3:0] FMT_JAL     = 4'd8;
    localparam logic [3:0] FMT_JALR    = 4'd9;
    localparam logic [3:0] FMT_LUI     = 4'd10;
    localparam logic [3:0] FMT_AUIPC   = 4'd11;
    localparam logic [3:0] FMT_FP      = 4'd12;

    // alu modes
    localparam logic [1:0] ALU_ADD  = 2'd0;
    localparam logic [1:0] ALU_CMP  = 2'd1;
    localparam logic [1:0] ALU_FUNC = 2'd2;

    // control flag bits
    localparam logic [9:0] FL_RW  = 10'h001;
    localparam logic [9:0] FL_IMM = 10'h002;
    localparam logic [9:0] FL_MRD = 10'h004;
    localparam logic [9:0] FL_MWR = 10'h008;
    localparam logic [9:0] FL_WFM = 10'h010;
    localparam logic [9:0] FL_BR  = 10'h020;
    localparam logic [9:0] FL_JMP = 10'h040;
    localparam logic [9:0] FL_P2R = 10'h080;
    localparam logic [9:0] FL_R2P = 10'h100;
    localparam logic [9:0] FL_CPC = 10'h200;

    // decode result, last field in the lowest bits
    typedef struct packed {
        logic [9:0]  control_flags;
        logic [1:0]  alu_mode;
        logic [31:0] imm_value;
        logic [4:0]  src2_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  dest_reg;
        logic [3:0]  format_code;
        logic [5:0]  operation_id;
    } dec_t;

    localparam int DEC_W = $bits(dec_t);

endpackage

>>> design/rv32_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// rv32_instruction_decoder_top
// Decoder for a subset of RV32IM plus flw, fsw, fadd.s and fsub.s.
// ----------------------------------------------------------------------------
// An instruction word enters on the slave stream and its decoded fields
// leave on the master stream: the word is captured in an input register,
// decoded by shallow bit slicing and written into the result register.
// Throughput is one transaction per clock unless stalled; a stalled master
// side holds the result register, and the input register still takes one
// more word, so the slave side backs up only when both registers are full.
module rv32_instruction_decoder_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // slave side, tdata: instruction_word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rvid_pkg::IN_TDATA_W-1:0]    s_tdata,
    // master side, tdata: operation_id, format_code, dest_reg, src1_reg,
    // src2_reg, imm_value, alu_mode, control_flags, zero fill
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rvid_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import rvid_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_t        out_data_reg;
    dec_t        dec;
    logic        out_ready;
    logic        in_ready;
    logic        in_load;

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;

    // stage handshakes
    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign in_load   = s_tvalid && in_ready;
    assign s_tready  = in_ready;

    assign in_valid_next  = in_load ? 1'b1 : (out_ready ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_word_reg <= s_tdata;
        end
        if (out_ready && in_valid_reg)
        begin
            out_data_reg <= dec;
        end
    end

    // instruction fields and immediates
    assign opc   = in_word_reg[6:0];
    assign f3    = in_word_reg[14:12];
    assign f7    = in_word_reg[31:25];
    assign imm_i = {{20{in_word_reg[31]}}, in_word_reg[31:20]};
    assign imm_s = {{20{in_word_reg[31]}}, in_word_reg[31:25], in_word_reg[11:7]};
    assign imm_b = {{19{in_word_reg[31]}}, in_word_reg[31], in_word_reg[7],
                    in_word_reg[30:25], in_word_reg[11:8], 1'b0};
    assign imm_j = {{11{in_word_reg[31]}}, in_word_reg[31], in_word_reg[19:12],
                    in_word_reg[20], in_word_reg[30:21], 1'b0};
    assign imm_u = {{12{in_word_reg[31]}}, in_word_reg[31:12]};

    // decode
    always_comb
    begin
        dec = '0;
        case (opc)
            OPC_R:
            begin
                dec.format_code   = FMT_R;
                dec.dest_reg      = in_word_reg[11:7];
                dec.src1_reg      = in_word_reg[19:15];
                dec.src2_reg      = in_word_reg[24:20];
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW;
                case (f7)
                    F7_BASE:
                    begin
                        case (f3)
                            3'd0:    dec.operation_id = OP_ADD;
                            3'd1:    dec.operation_id = OP_SLL;
                            3'd2:    dec.operation_id = OP_SLT;
                            3'd3:    dec.operation_id = OP_SLTU;
                            3'd4:    dec.operation_id = OP_XOR;
                            3'd5:    dec.operation_id = OP_SRL;
                            3'd6:    dec.operation_id = OP_OR;
                            default: dec.operation_id = OP_AND;
                        endcase
                    end
                    F7_MULD:
                    begin
                        case (f3)
                            3'd0:    dec.operation_id = OP_MUL;
                            3'd1:    dec.operation_id = OP_MULH;
                            3'd2:    dec.operation_id = OP_MULHSU;
                            3'd3:    dec.operation_id = OP_MULHU;
                            3'd4:    dec.operation_id = OP_DIV;
                            3'd5:    dec.operation_id = OP_DIVU;
                            3'd6:    dec.operation_id = OP_REM;
                            default: dec.operation_id = OP_REMU;
                        endcase
                    end
                    F7_ALT:
                    begin
                        case (f3)
                            3'd0:    dec.operation_id = OP_SUB;
                            3'd5:    dec.operation_id = OP_SRA;
                            default: dec.operation_id = OP_NONE;
                        endcase
                    end
                    default: dec.operation_id = OP_NONE;
                endcase
            end
            OPC_I:
            begin
                dec.format_code   = FMT_I;
                dec.dest_reg      = in_word_reg[11:7];
                dec.src1_reg      = in_word_reg[19:15];
                dec.imm_value     = imm_i;
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW | FL_IMM;
                // srli and srai share one number
                dec.operation_id  = OP_ADDI + {3'b000, f3};
            end
            OPC_LOAD:
            begin
                dec.format_code   = FMT_LOAD;
                dec.dest_reg      = in_word_reg[11:7];
                dec.src1_reg      = in_word_reg[19:15];
                dec.imm_value     = imm_i;
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW | FL_IMM | FL_MRD | FL_WFM;
                case (f3)
                    3'd0:    dec.operation_id = OP_LB;
                    3'd1:    dec.operation_id = OP_LH;
                    3'd2:    dec.operation_id = OP_LW;
                    3'd4:    dec.operation_id = OP_LBU;
                    3'd5:    dec.operation_id = OP_LHU;
                    3'd6:    dec.operation_id = OP_LWU;
                    default: dec.operation_id = OP_NONE;
                endcase
            end
            OPC_FLOAD:
            begin
                dec.format_code   = FMT_FLOAD;
                dec.dest_reg      = in_word_reg[11:7];
                dec.src1_reg      = in_word_reg[19:15];
                dec.imm_value     = imm_i;
                dec.alu_mode      = ALU_ADD;
                dec.control_flags = FL_RW | FL_IMM | FL_MRD | FL_WFM;
                dec.operation_id  = OP_FLW;
            end
            OPC_STORE:
            begin
                dec.format_code   = FMT_STORE;
                dec.src1_reg      = in_word_reg[19:15];
                dec.src2_reg      = in_word_reg[24:20];
                dec.imm_value     = imm_s;
                dec.alu_mode      = ALU_ADD;
                dec.control_flags = FL_MWR;
                if (f3 inside {[3'd0:3'd2]})
                begin
                    dec.operation_id = OP_SB + {3'b000, f3};
                end
                else
                begin
                    dec.operation_id = OP_NONE;
                end
            end
            OPC_FSTORE:
            begin
                dec.format_code   = FMT_FSTORE;
                dec.src1_reg      = in_word_reg[19:15];
                dec.src2_reg      = in_word_reg[24:20];
                dec.imm_value     = imm_s;
                dec.alu_mode      = ALU_ADD;
                dec.control_flags = FL_MWR;
                dec.operation_id  = OP_FSW;
            end
            OPC_BRANCH:
            begin
                dec.format_code   = FMT_B;
                dec.src1_reg      = in_word_reg[19:15];
                dec.src2_reg      = in_word_reg[24:20];
                dec.imm_value     = imm_b;
                dec.alu_mode      = ALU_CMP;
                dec.control_flags = FL_BR | FL_CPC;
                case (f3)
                    3'd0:    dec.operation_id = OP_BEQ;
                    3'd1:    dec.operation_id = OP_BNE;
                    3'd4:    dec.operation_id = OP_BLT;
                    3'd5:    dec.operation_id = OP_BGE;
                    3'd6:    dec.operation_id = OP_BLTU;
                    3'd7:    dec.operation_id = OP_BGEU;
                    default: dec.operation_id = OP_NONE;
                endcase
            end
            OPC_JAL:
            begin
                dec.format_code   = FMT_JAL;
                dec.dest_reg      = in_word_reg[11:7];
                dec.imm_value     = imm_j;
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW | FL_IMM | FL_JMP | FL_P2R | FL_CPC;
                dec.operation_id  = OP_JAL;
            end
            OPC_JALR:
            begin
                dec.format_code   = FMT_JALR;
                dec.dest_reg      = in_word_reg[11:7];
                dec.src1_reg      = in_word_reg[19:15];
                dec.imm_value     = imm_i;
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW | FL_IMM | FL_JMP | FL_P2R | FL_R2P | FL_CPC;
                dec.operation_id  = OP_JALR;
            end
            OPC_LUI:
            begin
                dec.format_code   = FMT_LUI;
                dec.dest_reg      = in_word_reg[11:7];
                dec.imm_value     = imm_u;
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW | FL_IMM;
                dec.operation_id  = OP_LUI;
            end
            OPC_AUIPC:
            begin
                dec.format_code   = FMT_AUIPC;
                dec.dest_reg      = in_word_reg[11:7];
                dec.imm_value     = imm_u;
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW | FL_IMM;
                dec.operation_id  = OP_AUIPC;
            end
            OPC_FP:
            begin
                dec.format_code   = FMT_FP;
                dec.dest_reg      = in_word_reg[11:7];
                dec.src1_reg      = in_word_reg[19:15];
                dec.src2_reg      = in_word_reg[24:20];
                dec.alu_mode      = ALU_FUNC;
                dec.control_flags = FL_RW;
                case (f7)
                    F7_FADD: dec.operation_id = OP_FADD;
                    F7_FSUB: dec.operation_id = OP_FSUB;
                    default: dec.operation_id = OP_NONE;
                endcase
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

    // master side outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DEC_W){1'b0}}, out_data_reg};

endmodule

>>> design/rvid_checker.sv
// ----------------------------------------------------------------------------
// rvid_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "rv32_instruction_decoder_top_macros.svh"

module rvid_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rvid_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rvid_pkg::*;

    logic [3:0]  fmt;
    logic [31:0] imm;
    logic [1:0]  alu;
    logic [9:0]  flags;

    // result fields
    assign fmt   = m_tdata[9:6];
    assign imm   = m_tdata[56:25];
    assign alu   = m_tdata[58:57];
    assign flags = m_tdata[68:59];

    // a stalled result transaction holds
    `RVID_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // unknown opcode gives an all-zero result
    `RVID_ASSERT_IMPL(a_unknown_zero, m_tvalid && fmt == FMT_UNKNOWN, m_tdata == '0)

    // register-register formats carry no immediate
    `RVID_ASSERT_IMPL(a_reg_fmt, m_tvalid && (fmt == FMT_R || fmt == FMT_FP),
                      imm == 32'd0 && alu == ALU_FUNC && flags == FL_RW)

    // pc changes only for branches and jumps
    `RVID_ASSERT_IMPL(a_cpc, m_tvalid && flags[9],
                      fmt == FMT_B || fmt == FMT_JAL || fmt == FMT_JALR)

endmodule

bind rv32_instruction_decoder_top rvid_checker u_rvid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: rv32 instruction decoder testbench
// Sends a table of hand-picked instruction words and then a long random mix
// of well-formed and garbage words through the decoder stream. Every decoded
// transaction is checked in order against a local decode function or typed
// row fields. Bursty input and a patterned output stall run the whole time.
// ----------------------------------------------------------------------------
module tb_top;

    import rvid_pkg::*;

    localparam int RANDOM_WORDS = 650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    // one word in flight with its expected decode
    typedef struct {
        logic [31:0] word;
        dec_t        fields;
    } pending_t;

    // one row of the directed table
    typedef struct {
        logic [31:0] word;
        bit          typed;
        dec_t        fields;
    } vector_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;     // instruction_word
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // operation_id, format_code, dest_reg,
                                         // src1_reg, src2_reg, imm_value,
                                         // alu_mode, control_flags, zero fill

    // sideband travelling with s_tdata: a typed expectation for table rows
    logic                   typed_valid;
    dec_t                   typed_fields;

    pending_t               pending_decodes[$];
    vector_t                vectors[$];
    int                     mismatch_count = 0;
    int                     accepted_words = 0;
    int                     idle_cycles = 0;
    int                     burst_left = 0;
    bit                     long_hold_done = 1'b0;
    dec_t                   got_fields;
    pending_t               head;

    rv32_instruction_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // decode one instruction word the way the block should
    function automatic dec_t decode_insn(input logic [31:0] w);
        dec_t       d;
        logic [6:0] f7;
        logic [2:0] f3;
        d  = '0;
        f7 = w[31:25];
        f3 = w[14:12];
        case (w[6:0])
            OPC_R:
            begin
                d.format_code   = FMT_R;
                d.dest_reg      = w[11:7];
                d.src1_reg      = w[19:15];
                d.src2_reg      = w[24:20];
                d.alu_mode      = ALU_FUNC;
                d.control_flags = FL_RW;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0: d.operation_id = OP_ADD;
                        3'd1: d.operation_id = OP_SLL;
                        3'd2: d.operation_id = OP_SLT;
                        3'd3: d.operation_id = OP_SLTU;
                        3'd4: d.operation_id = OP_XOR;
                        3'd5: d.operation_id = OP_SRL;
                        3'd6: d.operation_id = OP_OR;
                        default: d.operation_id = OP_AND;
                    endcase
                end
                else if (f7 == F7_MULD)
                begin
                    case (f3)
                        3'd0: d.operation_id = OP_MUL;
                        3'd1: d.operation_id = OP_MULH;
                        3'd2: d.operation_id = OP_MULHSU;
                        3'd3: d.operation_id = OP_MULHU;
                        3'd4: d.operation_id = OP_DIV;
                        3'd5: d.operation_id = OP_DIVU;
                        3'd6: d.operation_id = OP_REM;
                        default: d.operation_id = OP_REMU;
                    endcase
                end
                else if (f7 == F7_ALT)
                begin
                    if (f3 == 3'd0)
                        d.operation_id = OP_SUB;
                    else if (f3 == 3'd5)
                        d.operation_id = OP_SRA;
                    else
                        d.operation_id = OP_NONE;
                end
            end
            OPC_I:
            begin
                d.format_code   = FMT_I;
                d.dest_reg      = w[11:7];
                d.src1_reg      = w[19:15];
                d.imm_value     = {{20{w[31]}}, w[31:20]};
                d.alu_mode      = ALU_FUNC;
                d.control_flags = FL_RW | FL_IMM;
                // shift right immediate shares one number for both kinds
                d.operation_id  = OP_ADDI + 6'(f3);
            end
            OPC_LOAD, OPC_FLOAD:
            begin
                d.dest_reg      = w[11:7];
                d.src1_reg      = w[19:15];
                d.imm_value     = {{20{w[31]}}, w[31:20]};
                d.control_flags = FL_RW | FL_IMM | FL_MRD | FL_WFM;
                if (w[6:0] == OPC_FLOAD)
                begin
                    d.format_code  = FMT_FLOAD;
                    d.alu_mode     = ALU_ADD;
                    d.operation_id = OP_FLW;
                end
                else
                begin
                    d.format_code = FMT_LOAD;
                    d.alu_mode    = ALU_FUNC;
                    case (f3)
                        3'd0: d.operation_id = OP_LB;
                        3'd1: d.operation_id = OP_LH;
                        3'd2: d.operation_id = OP_LW;
                        3'd4: d.operation_id = OP_LBU;
                        3'd5: d.operation_id = OP_LHU;
                        3'd6: d.operation_id = OP_LWU;
                        default: d.operation_id = OP_NONE;
                    endcase
                end
            end
            OPC_STORE, OPC_FSTORE:
            begin
                d.format_code   = (w[6:0] == OPC_STORE) ? FMT_STORE : FMT_FSTORE;
                d.src1_reg      = w[19:15];
                d.src2_reg      = w[24:20];
                d.imm_value     = {{20{w[31]}}, w[31:25], w[11:7]};
                d.alu_mode      = ALU_ADD;
                d.control_flags = FL_MWR;
                if (w[6:0] == OPC_FSTORE)
                    d.operation_id = OP_FSW;
                else if (f3 < 3'd3)
                    d.operation_id = OP_SB + 6'(f3);
                else
                    d.operation_id = OP_NONE;
            end
            OPC_BRANCH:
            begin
                d.format_code   = FMT_B;
                d.src1_reg      = w[19:15];
                d.src2_reg      = w[24:20];
                d.imm_value     = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                d.alu_mode      = ALU_CMP;
                d.control_flags = FL_BR | FL_CPC;
                case (f3)
                    3'd0: d.operation_id = OP_BEQ;
                    3'd1: d.operation_id = OP_BNE;
                    3'd4: d.operation_id = OP_BLT;
                    3'd5: d.operation_id = OP_BGE;
                    3'd6: d.operation_id = OP_BLTU;
                    3'd7: d.operation_id = OP_BGEU;
                    default: d.operation_id = OP_NONE;
                endcase
            end
            OPC_JAL:
            begin
                d.format_code   = FMT_JAL;
                d.dest_reg      = w[11:7];
                d.imm_value     = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                d.alu_mode      = ALU_FUNC;
                d.control_flags = FL_RW | FL_IMM | FL_JMP | FL_P2R | FL_CPC;
                d.operation_id  = OP_JAL;
            end
            OPC_JALR:
            begin
                d.format_code   = FMT_JALR;
                d.dest_reg      = w[11:7];
                d.src1_reg      = w[19:15];
                d.imm_value     = {{20{w[31]}}, w[31:20]};
                d.alu_mode      = ALU_FUNC;
                d.control_flags = FL_RW | FL_IMM | FL_JMP | FL_P2R | FL_R2P | FL_CPC;
                d.operation_id  = OP_JALR;
            end
            OPC_LUI, OPC_AUIPC:
            begin
                d.format_code   = (w[6:0] == OPC_LUI) ? FMT_LUI : FMT_AUIPC;
                d.dest_reg      = w[11:7];
                // upper immediate is sign extended in place, not shifted
                d.imm_value     = {{12{w[31]}}, w[31:12]};
                d.alu_mode      = ALU_FUNC;
                d.control_flags = FL_RW | FL_IMM;
                d.operation_id  = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
            end
            OPC_FP:
            begin
                d.format_code   = FMT_FP;
                d.dest_reg      = w[11:7];
                d.src1_reg      = w[19:15];
                d.src2_reg      = w[24:20];
                d.alu_mode      = ALU_FUNC;
                d.control_flags = FL_RW;
                if (f7 == F7_FADD)
                    d.operation_id = OP_FADD;
                else if (f7 == F7_FSUB)
                    d.operation_id = OP_FSUB;
                else
                    d.operation_id = OP_NONE;
            end
            default:
                d = '0;
        endcase
        return d;
    endfunction

    // random word: mostly a known opcode with random fields, some pure noise
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 11))
                0:  w[6:0] = OPC_R;
                1:  w[6:0] = OPC_I;
                2:  w[6:0] = OPC_LOAD;
                3:  w[6:0] = OPC_FLOAD;
                4:  w[6:0] = OPC_STORE;
                5:  w[6:0] = OPC_FSTORE;
                6:  w[6:0] = OPC_BRANCH;
                7:  w[6:0] = OPC_JAL;
                8:  w[6:0] = OPC_JALR;
                9:  w[6:0] = OPC_LUI;
                10: w[6:0] = OPC_AUIPC;
                default: w[6:0] = OPC_FP;
            endcase
            // steer funct7 toward the listed codes most of the time
            if (w[6:0] == OPC_R)
            begin
                case ($urandom_range(0, 3))
                    0: w[31:25] = F7_BASE;
                    1: w[31:25] = F7_MULD;
                    2: w[31:25] = F7_ALT;
                    default: ;
                endcase
            end
            else if (w[6:0] == OPC_FP)
            begin
                case ($urandom_range(0, 2))
                    0: w[31:25] = F7_FADD;
                    1: w[31:25] = F7_FSUB;
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    // offer one word, honoring the burst and gap pattern
    task automatic offer_word(input logic [31:0] w, input bit typed, input dec_t fields);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid     <= 1'b1;
        s_tdata      <= w;
        typed_valid  <= typed;
        typed_fields <= fields;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending until every decode has come back
    task automatic drain_decodes();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_decodes.size() != 0);
    endtask

    task automatic add_vector(input logic [31:0] w, input bit typed, input dec_t fields);
        vector_t v;
        v.word   = w;
        v.typed  = typed;
        v.fields = fields;
        vectors.push_back(v);
    endtask

    // directed table, the random part and the end of the run
    initial
    begin
        dec_t lui_top;
        dec_t auipc_zero;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        typed_valid  = 1'b0;
        typed_fields = '0;

        lui_top               = '0;
        lui_top.operation_id  = OP_LUI;
        lui_top.format_code   = FMT_LUI;
        lui_top.dest_reg      = 5'd31;
        lui_top.imm_value     = 32'hFFFF_FFFF;
        lui_top.alu_mode      = ALU_FUNC;
        lui_top.control_flags = FL_RW | FL_IMM;
        auipc_zero               = '0;
        auipc_zero.operation_id  = OP_AUIPC;
        auipc_zero.format_code   = FMT_AUIPC;
        auipc_zero.alu_mode      = ALU_FUNC;
        auipc_zero.control_flags = FL_RW | FL_IMM;

        // unknown opcodes decode to all zeros, then typed lui and auipc rows
        add_vector(32'h0000_0000, 1'b1, '0);
        add_vector(32'hFFFF_FFFF, 1'b1, '0);
        add_vector({20'hFFFFF, 5'd31, OPC_LUI}, 1'b1, lui_top);
        add_vector({20'h00000, 5'd0, OPC_AUIPC}, 1'b1, auipc_zero);
        // register format: each funct7 group, then an unlisted funct7
        add_vector({F7_BASE, 5'd31, 5'd31, 3'd0, 5'd31, OPC_R}, 1'b0, '0);
        add_vector({F7_MULD, 5'd1, 5'd2, 3'd7, 5'd3, OPC_R}, 1'b0, '0);
        add_vector({F7_ALT, 5'd7, 5'd8, 3'd5, 5'd9, OPC_R}, 1'b0, '0);
        add_vector({F7_ALT, 5'd4, 5'd5, 3'd2, 5'd6, OPC_R}, 1'b0, '0);
        add_vector({7'h7F, 5'd4, 5'd5, 3'd6, 5'd6, OPC_R}, 1'b0, '0);
        // immediate ops, shift right arithmetic
        add_vector({12'hFFF, 5'd1, 3'd0, 5'd2, OPC_I}, 1'b0, '0);
        add_vector({F7_ALT, 5'd3, 5'd4, 3'd5, 5'd5, OPC_I}, 1'b0, '0);
        // loads: most negative offset, unlisted funct3, fp load ignores funct3
        add_vector({12'h800, 5'd3, 3'd2, 5'd4, OPC_LOAD}, 1'b0, '0);
        add_vector({12'h7FF, 5'd3, 3'd3, 5'd4, OPC_LOAD}, 1'b0, '0);
        add_vector({12'hABC, 5'd10, 3'd7, 5'd11, OPC_FLOAD}, 1'b0, '0);
        // stores: offset extremes, unlisted funct3, fp store ignores funct3
        add_vector({7'h40, 5'd5, 5'd6, 3'd2, 5'd0, OPC_STORE}, 1'b0, '0);
        add_vector({7'h3F, 5'd5, 5'd6, 3'd3, 5'd31, OPC_STORE}, 1'b0, '0);
        add_vector({7'h7F, 5'd5, 5'd6, 3'd5, 5'd31, OPC_FSTORE}, 1'b0, '0);
        // branches: most negative offset, a positive offset and a hole in the funct3 map
        add_vector({7'h40, 5'd0, 5'd0, 3'd0, 5'd0, OPC_BRANCH}, 1'b0, '0);
        add_vector({7'h3F, 5'd1, 5'd2, 3'd7, 5'd30, OPC_BRANCH}, 1'b0, '0);
        add_vector({7'h01, 5'd1, 5'd2, 3'd3, 5'd1, OPC_BRANCH}, 1'b0, '0);
        // jumps
        add_vector({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL}, 1'b0, '0);
        add_vector({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL}, 1'b0, '0);
        add_vector({12'hFFF, 5'd31, 3'd5, 5'd1, OPC_JALR}, 1'b0, '0);
        // fp add, sub and an unlisted funct7
        add_vector({F7_FADD, 5'd1, 5'd2, 3'd7, 5'd3, OPC_FP}, 1'b0, '0);
        add_vector({F7_FSUB, 5'd31, 5'd0, 3'd0, 5'd31, OPC_FP}, 1'b0, '0);
        add_vector({7'h7F, 5'd9, 5'd10, 3'd1, 5'd11, OPC_FP}, 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
            offer_word(vectors[i].word, vectors[i].typed, vectors[i].fields);
        drain_decodes();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 420)
                drain_decodes();
            offer_word(random_word(), 1'b0, '0);
        end

        drain_decodes();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // output side stall pattern, with one long hold while input keeps coming
    initial
    begin
        int mode;
        int span;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && accepted_words >= HOLD_AFTER)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                for (int k = 0; k < span; k++)
                begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= ($urandom_range(0, 3) != 0);
                        2: m_tready <= k[1];
                        default: m_tready <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // record accepted words and check decoded transactions in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                head.word   = s_tdata;
                head.fields = typed_valid ? typed_fields : decode_insn(s_tdata);
                pending_decodes.push_back(head);
                accepted_words++;
            end
            if (m_tvalid && m_tready)
            begin
                got_fields = dec_t'(m_tdata[DEC_W-1:0]);
                if (pending_decodes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected decode transaction: %h", m_tdata);
                end
                else
                begin
                    head = pending_decodes.pop_front();
                    if (got_fields.operation_id  !== head.fields.operation_id  ||
                        got_fields.format_code   !== head.fields.format_code   ||
                        got_fields.dest_reg      !== head.fields.dest_reg      ||
                        got_fields.src1_reg      !== head.fields.src1_reg      ||
                        got_fields.src2_reg      !== head.fields.src2_reg      ||
                        got_fields.imm_value     !== head.fields.imm_value     ||
                        got_fields.alu_mode      !== head.fields.alu_mode      ||
                        got_fields.control_flags !== head.fields.control_flags ||
                        m_tdata[OUT_TDATA_W-1:DEC_W] !== '0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("decode mismatch for %h", head.word);
                            $display("  exp op=%0d fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h alu=%0d flags=%h",
                                     head.fields.operation_id, head.fields.format_code,
                                     head.fields.dest_reg, head.fields.src1_reg,
                                     head.fields.src2_reg, head.fields.imm_value,
                                     head.fields.alu_mode, head.fields.control_flags);
                            $display("  got op=%0d fmt=%0d rd=%0d rs1=%0d rs2=%0d imm=%h alu=%0d flags=%h fill=%0h",
                                     got_fields.operation_id, got_fields.format_code,
                                     got_fields.dest_reg, got_fields.src1_reg,
                                     got_fields.src2_reg, got_fields.imm_value,
                                     got_fields.alu_mode, got_fields.control_flags,
                                     m_tdata[OUT_TDATA_W-1:DEC_W]);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
